// ----- rtl/core/byte_unstuff_deframer_core_defines.svh -----
// assertion macros used by bud_tx
`ifndef BYTE_UNSTUFF_DEFRAMER_CORE_DEFINES_SVH
`define BYTE_UNSTUFF_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BUD_ASSERT_HOLD(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define BUD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BUD_ASSERT_HOLD(label, clk, rst, prop)
`define BUD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/bud_pkg.sv -----
package bud_pkg;

   localparam int STORE_DEPTH = 64;
   localparam int ADDR_W = 6;
   localparam int LEN_W = 7;
   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h7D;
   localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
   localparam logic [BYTE_W-1:0] ESC_XOR = 8'h20;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] len;
   } drain_type;

endpackage

// ----- rtl/core/byte_unstuff_deframer_core.sv -----
// Byte-unstuffing frame receiver. One received byte is taken per cycle while
// no frame is being read out: 0x7D escapes the next byte (XOR 0x20), 0x7E
// closes the frame, anything else is stored in a 64-entry frame RAM up to
// FRAME_MAX bytes (extra bytes are dropped). A flag with a non-empty buffer
// starts readout; req_ready then stays low until the last RAM read of the
// frame has been issued. Readout is paced by the RAM's registered read feeding
// the output register: a new RAM read is issued only when no earlier read is
// still pending and the output register is empty or rsp_ready is high. Every
// beat carries the frame length, and the final beat has frame_last set.
module byte_unstuff_deframer_core #(
   parameter int FRAME_MAX = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [bud_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [bud_pkg::BYTE_W-1:0] rsp_frame_byte,
   output logic                       rsp_frame_last,
   output logic [bud_pkg::LEN_W-1:0]  rsp_frame_length
);

   bud_pkg::wr_type            wr;
   bud_pkg::drain_type         drain;
   logic                       busy;
   logic                       rd_en;
   logic [bud_pkg::ADDR_W-1:0] rd_addr;
   logic [bud_pkg::BYTE_W-1:0] rd_data;

   assign req_ready = !busy;

   bud_rx #(
      .FRAME_MAX(FRAME_MAX)
   ) u_rx (
      .clock  (clock),
      .reset  (reset),
      .beat   (req_valid && req_ready),
      .rx_byte(req_rx_byte),
      .wr     (wr),
      .drain  (drain)
   );

   bud_ram #(
      .WIDTH(bud_pkg::BYTE_W),
      .DEPTH(bud_pkg::STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr.en),
      .wr_addr(wr.addr),
      .wr_data(wr.data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   bud_tx u_tx (
      .clock           (clock),
      .reset           (reset),
      .drain           (drain),
      .busy            (busy),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_frame_last  (rsp_frame_last),
      .rsp_frame_length(rsp_frame_length)
   );

endmodule

// ----- rtl/core/bud_ram.sv -----
module bud_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bud_rx.sv -----
module bud_rx #(
   parameter int FRAME_MAX = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       beat,
   input  logic [bud_pkg::BYTE_W-1:0] rx_byte,
   output bud_pkg::wr_type            wr,
   output bud_pkg::drain_type         drain
);

   localparam logic [bud_pkg::LEN_W-1:0] LIMIT = bud_pkg::LEN_W'(FRAME_MAX);

   logic                      esc_ff, esc_in;
   logic [bud_pkg::LEN_W-1:0] fill_ff, fill_in;
   logic                      is_esc, is_flag;

   assign is_esc = (rx_byte == bud_pkg::ESC_BYTE) && !esc_ff;
   assign is_flag = (rx_byte == bud_pkg::FLAG_BYTE) && !esc_ff;

   always_comb begin
      esc_in = esc_ff;
      fill_in = fill_ff;
      wr.en = 1'b0;
      wr.addr = fill_ff[bud_pkg::ADDR_W-1:0];
      wr.data = esc_ff ? (rx_byte ^ bud_pkg::ESC_XOR) : rx_byte;
      drain.start = 1'b0;
      drain.len = fill_ff;
      if (beat) begin
         if (is_esc) begin
            esc_in = 1'b1;
         end else if (is_flag) begin
            fill_in = '0;
            drain.start = (fill_ff != '0);
         end else begin
            esc_in = 1'b0;
            if (fill_ff < LIMIT) begin
               wr.en = 1'b1;
               fill_in = fill_ff + bud_pkg::LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         esc_ff <= esc_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// ----- rtl/core/bud_tx.sv -----
`include "byte_unstuff_deframer_core_defines.svh"

module bud_tx (
   input  logic                       clock,
   input  logic                       reset,
   input  bud_pkg::drain_type         drain,
   output logic                       busy,
   output logic                       rd_en,
   output logic [bud_pkg::ADDR_W-1:0] rd_addr,
   input  logic [bud_pkg::BYTE_W-1:0] rd_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [bud_pkg::BYTE_W-1:0] rsp_frame_byte,
   output logic                       rsp_frame_last,
   output logic [bud_pkg::LEN_W-1:0]  rsp_frame_length
);

   logic                       drain_ff, drain_in;
   logic [bud_pkg::LEN_W-1:0]  idx_ff, idx_in;
   logic [bud_pkg::LEN_W-1:0]  len_ff, len_in;
   logic                       pend_ff, pend_last_ff;
   logic                       out_valid_ff, out_valid_in;
   logic [bud_pkg::BYTE_W-1:0] out_byte_ff;
   logic                       out_last_ff;
   logic [bud_pkg::LEN_W-1:0]  out_len_ff;
   logic                       issue, last_rd;

   assign issue = drain_ff && !pend_ff && (!out_valid_ff || rsp_ready);
   assign last_rd = (idx_ff + bud_pkg::LEN_W'(1)) == len_ff;

   always_comb begin
      drain_in = drain_ff;
      idx_in = idx_ff;
      len_in = len_ff;
      if (drain.start) begin
         drain_in = 1'b1;
         idx_in = '0;
         len_in = drain.len;
      end else if (issue) begin
         idx_in = idx_ff + bud_pkg::LEN_W'(1);
         if (last_rd) begin
            drain_in = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pend_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff <= 1'b0;
         idx_ff <= '0;
         len_ff <= '0;
         pend_ff <= 1'b0;
         pend_last_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         drain_ff <= drain_in;
         idx_ff <= idx_in;
         len_ff <= len_in;
         pend_ff <= issue;
         pend_last_ff <= issue && last_rd;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload of the output beat
   always_ff @(posedge clock) begin
      if (pend_ff) begin
         out_byte_ff <= rd_data;
         out_last_ff <= pend_last_ff;
         out_len_ff <= len_ff;
      end
   end

   assign busy = drain_ff;
   assign rd_en = issue;
   assign rd_addr = idx_ff[bud_pkg::ADDR_W-1:0];
   assign rsp_valid = out_valid_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_frame_last = out_last_ff;
   assign rsp_frame_length = out_len_ff;

   `BUD_ASSERT_NEXT(a_issue_frees_out, clock, reset, issue, !out_valid_ff)
   `BUD_ASSERT_HOLD(a_idx_in_frame, clock, reset, drain_ff |-> (idx_ff < len_ff))
   `BUD_ASSERT_HOLD(a_start_when_idle, clock, reset, drain.start |-> !drain_ff)

endmodule
